>>> rtl/led_matrix_framebuffer_engine_assert.svh
// assertion macros for the led matrix framebuffer engine
// depends on nothing; taken in by the rtl files that carry assertions
`ifndef LED_MATRIX_FRAMEBUFFER_ENGINE_ASSERT_SVH
`define LED_MATRIX_FRAMEBUFFER_ENGINE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LMFE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define LMFE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lmfe_pkg.sv
// types and constants of the led matrix framebuffer engine
// no dependencies; imported by the top level
package lmfe_pkg;

  // command codes carried in the input tuser
  typedef enum logic [2:0] {
    FUNC_CLEAR   = 3'd0,
    FUNC_PIXEL   = 3'd1,
    FUNC_FILL    = 3'd2,
    FUNC_OUTLINE = 3'd3,
    FUNC_SHOW    = 3'd4,
    FUNC_INIT    = 3'd5
  } func_t;

  // color codes
  localparam logic [1:0] COLOR_OFF     = 2'd0;
  localparam logic [1:0] COLOR_CHECKER = 2'd2;

  // stream widths
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

  // driver init sequence, each entry repeated once per module
  localparam int INIT_STEPS  = 5;
  localparam int STEP_W      = 3;
  localparam logic [3:0] INIT_ADDR [INIT_STEPS] = '{4'hF, 4'h9, 4'hA, 4'hB, 4'hC};
  localparam logic [7:0] INIT_DATA [INIT_STEPS] = '{8'h00, 8'h00, 8'h00, 8'h07, 8'h01};

endpackage

>>> rtl/led_matrix_framebuffer_engine.sv
// led matrix framebuffer engine: one-bit framebuffer in a small synchronous ram
// depends on lmfe_pkg and led_matrix_framebuffer_engine_assert.svh
// commands: clear takes effect at accept; pixel/fill/outline do one ram read-modify-write
//   per row, read and write of adjacent rows overlap; show emits one pair per module and row,
//   init one per module and entry; one result per cycle through the single output register
//   while out_tready is high; throughput: one command at a time, accepted only in idle
// reset: synchronous; control and row valid bits clear, so the frame reads all zeros
`include "led_matrix_framebuffer_engine_assert.svh"

module led_matrix_framebuffer_engine #(
  parameter int MODULE_COUNT = 4,
  parameter int ROW_COUNT    = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // command channel
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // x_pos[7:0] y_pos[15:8] rect_width[23:16] rect_height[31:24] color[33:32]
  // blink_phase[34] zero[39:35]
  input  logic [lmfe_pkg::IN_DATA_W-1:0]  in_tdata,
  // func[2:0]
  input  logic [2:0]                      in_tuser,
  // result channel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // reg_addr[3:0] reg_data[11:4] zero[15:12]
  output logic [lmfe_pkg::OUT_DATA_W-1:0] out_tdata,
  // select_end[0]
  output logic [0:0]                      out_tuser,
  output logic                            out_tlast
);
  import lmfe_pkg::*;

  localparam int COLS  = 8 * MODULE_COUNT;
  localparam int ROW_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int MOD_W = (MODULE_COUNT > 1) ? $clog2(MODULE_COUNT) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAW,
    ST_SHOW_RD,
    ST_SHOW_OUT,
    ST_INIT
  } state_t;

  // input fields
  logic [7:0] x0, y0, wd, ht;
  logic [1:0] color_in;
  logic       phase_in;
  func_t      func_in;
  logic       in_fire;

  assign x0       = in_tdata[7:0];
  assign y0       = in_tdata[15:8];
  assign wd       = in_tdata[23:16];
  assign ht       = in_tdata[31:24];
  assign color_in = in_tdata[33:32];
  assign phase_in = in_tdata[34];
  assign func_in  = func_t'(in_tuser);
  assign in_fire  = in_tvalid && in_tready;

  // control and command registers
  state_t                state_r, state_nxt;
  logic [ROW_W-1:0]      row_r, row_nxt;
  logic [MOD_W-1:0]      mod_r, mod_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [COLS-1:0]       cmask_h_r, cmask_h_nxt;
  logic [COLS-1:0]       cmask_v_r, cmask_v_nxt;
  logic [ROW_COUNT-1:0]  rsel_h_r, rsel_h_nxt;
  logic [ROW_COUNT-1:0]  rsel_v_r, rsel_v_nxt;
  logic [1:0]            color_r, color_nxt;
  logic                  phase_r, phase_nxt;
  logic                  wr_pend_r, wr_pend_nxt;
  logic [ROW_W-1:0]      wr_row_r, wr_row_nxt;
  logic [ROW_COUNT-1:0]  row_vld_r, row_vld_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [3:0]            out_addr_r, out_addr_nxt;
  logic [7:0]            out_data_r, out_data_nxt;
  logic                  out_sel_r, out_sel_nxt;
  logic                  out_last_r, out_last_nxt;

  // framebuffer ram
  logic [COLS-1:0]       mem [ROW_COUNT];
  logic [COLS-1:0]       rd_data_r;
  logic                  rd_vld_r;
  logic                  rd_en, wr_en;
  logic [ROW_W-1:0]      rd_addr;
  logic [COLS-1:0]       wr_data;

  // per-command column and row masks, decoded at accept
  logic [8:0]           x_end, x_last, y_end, y_last;
  logic [COLS-1:0]      col_rng, col_pix, col_edge;
  logic [ROW_COUNT-1:0] row_rng, row_pix, row_edge, row_in;
  logic                 zero_size;

  always_comb begin
    x_end     = {1'b0, x0} + {1'b0, wd};
    x_last    = x_end - 9'd1;
    y_end     = {1'b0, y0} + {1'b0, ht};
    y_last    = y_end - 9'd1;
    zero_size = (wd == 8'd0) || (ht == 8'd0);
    for (int x = 0; x < COLS; x++) begin
      col_rng[COLS-1-x]  = (9'(x) >= {1'b0, x0}) && (9'(x) < x_end);
      col_pix[COLS-1-x]  = (9'(x) == {1'b0, x0});
      col_edge[COLS-1-x] = (9'(x) == {1'b0, x0}) || (9'(x) == x_last);
    end
    for (int r = 0; r < ROW_COUNT; r++) begin
      row_rng[r]  = (9'(r) >= {1'b0, y0}) && (9'(r) < y_end);
      row_pix[r]  = (9'(r) == {1'b0, y0});
      row_edge[r] = (9'(r) == {1'b0, y0}) || (9'(r) == y_last);
      row_in[r]   = (9'(r) > {1'b0, y0}) && (9'(r) < y_end);
    end
  end

  // modify stage: merge the masked color into the row just read
  logic [COLS-1:0] old_row, row_mask, pat, color_word;

  always_comb begin
    old_row  = rd_vld_r ? rd_data_r : '0;
    row_mask = (rsel_h_r[wr_row_r] ? cmask_h_r : '0) | (rsel_v_r[wr_row_r] ? cmask_v_r : '0);
    for (int x = 0; x < COLS; x++) begin
      pat[COLS-1-x] = 1'(x) ^ wr_row_r[0] ^ phase_r;
    end
    if (color_r == COLOR_CHECKER) begin
      color_word = pat;
    end else if (color_r == COLOR_OFF) begin
      color_word = '0;
    end else begin
      color_word = '1;
    end
    wr_data = (old_row & ~row_mask) | (row_mask & color_word);
    wr_en   = wr_pend_r;
  end

  // byte view of the row held at the ram output
  logic [7:0]       row_bytes [MODULE_COUNT];
  logic [MOD_W-1:0] byte_idx;

  always_comb begin
    for (int k = 0; k < MODULE_COUNT; k++) begin
      row_bytes[k] = old_row[8*k +: 8];
    end
    byte_idx = MOD_W'(MODULE_COUNT - 1) - mod_r;
  end

  // next-state logic
  logic out_free, mod_end, row_end, step_end;

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    mod_nxt       = mod_r;
    step_nxt      = step_r;
    cmask_h_nxt   = cmask_h_r;
    cmask_v_nxt   = cmask_v_r;
    rsel_h_nxt    = rsel_h_r;
    rsel_v_nxt    = rsel_v_r;
    color_nxt     = color_r;
    phase_nxt     = phase_r;
    wr_pend_nxt   = 1'b0;
    wr_row_nxt    = wr_row_r;
    row_vld_nxt   = row_vld_r;
    out_addr_nxt  = out_addr_r;
    out_data_nxt  = out_data_r;
    out_sel_nxt   = out_sel_r;
    out_last_nxt  = out_last_r;
    rd_en         = 1'b0;
    rd_addr       = row_r;
    out_free      = !out_valid_r || out_tready;
    out_valid_nxt = out_valid_r && !out_tready;
    mod_end       = (mod_r == MOD_W'(MODULE_COUNT - 1));
    row_end       = (row_r == ROW_W'(ROW_COUNT - 1));
    step_end      = (step_r == STEP_W'(INIT_STEPS - 1));

    // written rows become valid
    if (wr_en) begin
      row_vld_nxt[wr_row_r] = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          row_nxt     = '0;
          mod_nxt     = '0;
          step_nxt    = '0;
          color_nxt   = color_in;
          phase_nxt   = phase_in;
          cmask_h_nxt = col_rng;
          cmask_v_nxt = col_edge;
          rsel_h_nxt  = '0;
          rsel_v_nxt  = '0;
          case (func_in)
            FUNC_CLEAR: begin
              // clear wins over a write still in flight
              row_vld_nxt = '0;
            end
            FUNC_PIXEL: begin
              cmask_h_nxt = col_pix;
              rsel_h_nxt  = row_pix;
              state_nxt   = ST_DRAW;
            end
            FUNC_FILL: begin
              rsel_h_nxt = zero_size ? '0 : row_rng;
              state_nxt  = ST_DRAW;
            end
            FUNC_OUTLINE: begin
              rsel_h_nxt = zero_size ? '0 : row_edge;
              rsel_v_nxt = zero_size ? '0 : row_in;
              state_nxt  = ST_DRAW;
            end
            FUNC_SHOW: begin
              state_nxt = ST_SHOW_RD;
            end
            FUNC_INIT: begin
              state_nxt = ST_INIT;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      // read one row a cycle, write it back in the next
      ST_DRAW: begin
        rd_en       = 1'b1;
        wr_pend_nxt = 1'b1;
        wr_row_nxt  = row_r;
        if (row_end) begin
          state_nxt = ST_IDLE;
        end else begin
          row_nxt = row_r + ROW_W'(1);
        end
      end

      ST_SHOW_RD: begin
        rd_en     = 1'b1;
        state_nxt = ST_SHOW_OUT;
      end

      // one byte pair per transaction, next row fetched on the row's last byte
      ST_SHOW_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = 4'(row_r) + 4'd1;
          out_data_nxt  = row_bytes[byte_idx];
          out_sel_nxt   = mod_end;
          out_last_nxt  = mod_end && row_end;
          if (mod_end) begin
            mod_nxt = '0;
            if (row_end) begin
              state_nxt = ST_IDLE;
            end else begin
              row_nxt = row_r + ROW_W'(1);
              rd_en   = 1'b1;
              rd_addr = row_r + ROW_W'(1);
            end
          end else begin
            mod_nxt = mod_r + MOD_W'(1);
          end
        end
      end

      // driver settings, each repeated once per module
      ST_INIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = INIT_ADDR[step_r];
          out_data_nxt  = INIT_DATA[step_r];
          out_sel_nxt   = mod_end;
          out_last_nxt  = mod_end && step_end;
          if (mod_end) begin
            mod_nxt = '0;
            if (step_end) begin
              state_nxt = ST_IDLE;
            end else begin
              step_nxt = step_r + STEP_W'(1);
            end
          end else begin
            mod_nxt = mod_r + MOD_W'(1);
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wr_pend_r   <= 1'b0;
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
      row_r       <= '0;
      mod_r       <= '0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      wr_pend_r   <= wr_pend_nxt;
      row_vld_r   <= row_vld_nxt;
      out_valid_r <= out_valid_nxt;
      row_r       <= row_nxt;
      mod_r       <= mod_nxt;
      step_r      <= step_nxt;
    end
    cmask_h_r  <= cmask_h_nxt;
    cmask_v_r  <= cmask_v_nxt;
    rsel_h_r   <= rsel_h_nxt;
    rsel_v_r   <= rsel_v_nxt;
    color_r    <= color_nxt;
    phase_r    <= phase_nxt;
    wr_row_r   <= wr_row_nxt;
    out_addr_r <= out_addr_nxt;
    out_data_r <= out_data_nxt;
    out_sel_r  <= out_sel_nxt;
    out_last_r <= out_last_nxt;
  end

  // framebuffer ram, one read and one write port, registered read data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row_r] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= row_vld_r[rd_addr];
    end
  end

  // ports
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_data_r, out_addr_r};
  assign out_tuser  = out_sel_r;
  assign out_tlast  = out_last_r;

  // assertions
  `LMFE_ASSERT_IMP(a_no_rw_same_row, clk, rst_n, rd_en && wr_en, rd_addr != wr_row_r,
    "read and write of the same framebuffer row in one cycle")
  `LMFE_ASSERT_IMP(a_write_follows_draw, clk, rst_n, wr_pend_r, $past(state_r == ST_DRAW),
    "row write-back without a preceding draw read")
  `LMFE_ASSERT_NXT(a_clear_empties, clk, rst_n, in_fire && (func_in == FUNC_CLEAR),
    row_vld_r == '0, "clear left a valid framebuffer row")
  `LMFE_ASSERT_IMP(a_last_ends_select, clk, rst_n, out_tvalid && out_tlast, out_tuser[0],
    "final pair of a run does not end the chip select group")

endmodule
